// File: rtl/core/detection_box_decode_unit_assert.svh
// assertion macros for the detection box decode unit
// used by the top level only, no other dependencies
`ifndef DETECTION_BOX_DECODE_UNIT_ASSERT_SVH
`define DETECTION_BOX_DECODE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define DBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("detection box decode: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define DBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("detection box decode: next-cycle check failed");

`endif

// File: rtl/core/dbd_pkg.sv
// shared widths, register indexes, class codes and lane control type
// for the detection box decode unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

   localparam int FRAC_BITS   = 4;
   localparam int COORD_W     = 16;
   localparam int SCORE_W     = 16;
   localparam int GAIN_W      = 20;
   localparam int MAX_W       = 12;
   localparam int CLASS_W     = 2;
   localparam int REG_IDX_W   = 3;
   localparam int CSR_DATA_W  = 20;

   // doubled-unit corner, product and rounded quotient
   localparam int DIFF_W      = COORD_W + 3;
   localparam int PROD_W      = DIFF_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = 17;
   localparam int QUOT_W      = PROD_W - ROUND_SHIFT;
   localparam int LIM_CALC_W  = 24;

   localparam logic [COORD_W-1:0] COORD_MAX = '1;

   localparam logic [REG_IDX_W-1:0] REG_SCORE_MIN = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_INV_GAIN  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PAD_X     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PAD_Y     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_X     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MAX_Y     = 3'd5;

   localparam logic [SCORE_W-1:0] SCORE_MIN_RESET = 16'd16384;
   localparam logic [GAIN_W-1:0]  INV_GAIN_RESET  = 20'd65536;
   localparam logic [COORD_W-1:0] PAD_RESET       = 16'd0;
   localparam logic [MAX_W-1:0]   MAX_X_RESET     = 12'd1279;
   localparam logic [MAX_W-1:0]   MAX_Y_RESET     = 12'd735;

   localparam logic [CLASS_W-1:0] CLASS_ID_0 = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_ID_1 = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_ID_2 = 2'd2;

   typedef struct packed {
      logic load_diff;
      logic load_prod;
      logic load_out;
   } lane_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/detection_box_decode_unit.sv
// detection box decode unit: one anchor row per beat into a clamped image box
// four corner lanes and a class pick; depends on dbd_pkg, dbd_class_pick,
// dbd_corner_lane and detection_box_decode_unit_assert.svh
//
// usage
// - req channel: one anchor row per beat (centre, size, three class scores),
//   taken when req_valid is high and req_stall is low
// - rsp channel: one box per kept row (corners, confidence, class id),
//   taken when rsp_valid is high and rsp_stall is low
// - rows whose best score is below the threshold give no rsp beat
// - csr port: write-only, one register per cycle, written while idle
// - req beat to rsp_valid through the three register stages of each corner
//   lane (corner, gain multiply, round and clamp); one row per cycle while
//   rsp_stall is low
// - rsp_stall holds the pipeline; bubbles close up, and req_stall rises
//   only once every stage holds a row
// - reset: synchronous, clears the stage valid bits and loads the register
//   defaults (threshold 0.25, unit gain, no padding, 1280 x 736 image)
`timescale 1ns / 1ps
`default_nettype none
`include "detection_box_decode_unit_assert.svh"

module detection_box_decode_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [dbd_pkg::COORD_W-1:0]   req_center_x,
   input  wire logic signed [dbd_pkg::COORD_W-1:0]   req_center_y,
   input  wire logic        [dbd_pkg::COORD_W-1:0]   req_box_w,
   input  wire logic        [dbd_pkg::COORD_W-1:0]   req_box_h,
   input  wire logic        [dbd_pkg::SCORE_W-1:0]   req_class_score_0,
   input  wire logic        [dbd_pkg::SCORE_W-1:0]   req_class_score_1,
   input  wire logic        [dbd_pkg::SCORE_W-1:0]   req_class_score_2,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic             [dbd_pkg::COORD_W-1:0]   rsp_left,
   output logic             [dbd_pkg::COORD_W-1:0]   rsp_top,
   output logic             [dbd_pkg::COORD_W-1:0]   rsp_right,
   output logic             [dbd_pkg::COORD_W-1:0]   rsp_bottom,
   output logic             [dbd_pkg::SCORE_W-1:0]   rsp_confidence,
   output logic             [dbd_pkg::CLASS_W-1:0]   rsp_class_id,
   input  wire logic                                 csr_wr_en,
   input  wire logic        [dbd_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic        [dbd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dbd_pkg::*;

   // configuration registers
   logic        [SCORE_W-1:0] score_min_ff;
   logic        [GAIN_W-1:0]  inv_gain_ff;
   logic signed [COORD_W-1:0] pad_x_ff;
   logic signed [COORD_W-1:0] pad_y_ff;
   logic        [MAX_W-1:0]   max_x_ff;
   logic        [MAX_W-1:0]   max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_min_ff <= SCORE_MIN_RESET;
         inv_gain_ff  <= INV_GAIN_RESET;
         pad_x_ff     <= PAD_RESET;
         pad_y_ff     <= PAD_RESET;
         max_x_ff     <= MAX_X_RESET;
         max_y_ff     <= MAX_Y_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SCORE_MIN: score_min_ff <= csr_wdata[SCORE_W-1:0];
            REG_INV_GAIN:  inv_gain_ff  <= csr_wdata[GAIN_W-1:0];
            REG_PAD_X:     pad_x_ff     <= csr_wdata[COORD_W-1:0];
            REG_PAD_Y:     pad_y_ff     <= csr_wdata[COORD_W-1:0];
            REG_MAX_X:     max_x_ff     <= csr_wdata[MAX_W-1:0];
            REG_MAX_Y:     max_y_ff     <= csr_wdata[MAX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp limits in image space, saturated to the coordinate width
   logic [LIM_CALC_W-1:0] lim_x_wide;
   logic [LIM_CALC_W-1:0] lim_y_wide;
   logic [COORD_W-1:0]    lim_x;
   logic [COORD_W-1:0]    lim_y;

   always_comb begin
      lim_x_wide = LIM_CALC_W'(max_x_ff) << FRAC_BITS;
      lim_y_wide = LIM_CALC_W'(max_y_ff) << FRAC_BITS;
      lim_x = (lim_x_wide > LIM_CALC_W'(COORD_MAX)) ? COORD_MAX : lim_x_wide[COORD_W-1:0];
      lim_y = (lim_y_wide > LIM_CALC_W'(COORD_MAX)) ? COORD_MAX : lim_y_wide[COORD_W-1:0];
   end

   // class pick
   logic [SCORE_W-1:0] best;
   logic [CLASS_W-1:0] best_id;
   logic               keep;

   dbd_class_pick u_class_pick (
      .score_0   (req_class_score_0),
      .score_1   (req_class_score_1),
      .score_2   (req_class_score_2),
      .threshold (score_min_ff),
      .best      (best),
      .best_id   (best_id),
      .keep      (keep)
   );

   // pipeline control
   logic valid1_ff, valid2_ff, valid3_ff;
   logic ready1, ready2, ready3;
   logic req_take;
   lane_ctl_type lane_ctl;

   assign ready3   = !valid3_ff || !rsp_stall;
   assign ready2   = !valid2_ff || ready3;
   assign ready1   = !valid1_ff || ready2;
   assign req_take = req_valid && ready1;

   assign lane_ctl.load_diff = ready1;
   assign lane_ctl.load_prod = ready2;
   assign lane_ctl.load_out  = ready3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            valid1_ff <= req_take && keep;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
         if (ready3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   // confidence and class ride alongside the lanes
   logic [SCORE_W-1:0] conf1_ff, conf2_ff, conf3_ff;
   logic [CLASS_W-1:0] cls1_ff, cls2_ff, cls3_ff;

   always_ff @(posedge clock) begin
      if (ready1) begin
         conf1_ff <= best;
         cls1_ff  <= best_id;
      end
      if (ready2) begin
         conf2_ff <= conf1_ff;
         cls2_ff  <= cls1_ff;
      end
      if (ready3) begin
         conf3_ff <= conf2_ff;
         cls3_ff  <= cls2_ff;
      end
   end

   // corner lanes
   dbd_corner_lane u_lane_left (
      .clock    (clock),
      .ctl      (lane_ctl),
      .center   (req_center_x),
      .size     (req_box_w),
      .sub_size (1'b1),
      .pad      (pad_x_ff),
      .inv_gain (inv_gain_ff),
      .lim      (lim_x),
      .corner   (rsp_left)
   );

   dbd_corner_lane u_lane_top (
      .clock    (clock),
      .ctl      (lane_ctl),
      .center   (req_center_y),
      .size     (req_box_h),
      .sub_size (1'b1),
      .pad      (pad_y_ff),
      .inv_gain (inv_gain_ff),
      .lim      (lim_y),
      .corner   (rsp_top)
   );

   dbd_corner_lane u_lane_right (
      .clock    (clock),
      .ctl      (lane_ctl),
      .center   (req_center_x),
      .size     (req_box_w),
      .sub_size (1'b0),
      .pad      (pad_x_ff),
      .inv_gain (inv_gain_ff),
      .lim      (lim_x),
      .corner   (rsp_right)
   );

   dbd_corner_lane u_lane_bottom (
      .clock    (clock),
      .ctl      (lane_ctl),
      .center   (req_center_y),
      .size     (req_box_h),
      .sub_size (1'b0),
      .pad      (pad_y_ff),
      .inv_gain (inv_gain_ff),
      .lim      (lim_y),
      .corner   (rsp_bottom)
   );

   assign req_stall      = !ready1;
   assign rsp_valid      = valid3_ff;
   assign rsp_confidence = conf3_ff;
   assign rsp_class_id   = cls3_ff;

   // a dropped row never enters the pipeline
   `DBD_ASSERT_NEXT(a_drop_no_entry, clock, reset, req_take && !keep, !valid1_ff)
   // a row held in the middle stage is not lost while the output is blocked
   `DBD_ASSERT_NEXT(a_mid_held, clock, reset, valid2_ff && !ready3, valid2_ff)
   // output empties after a taken beat when nothing follows
   `DBD_ASSERT_NEXT(a_out_drains, clock, reset, valid3_ff && !rsp_stall && !valid2_ff, !valid3_ff)
   // only real class codes leave the block
   `DBD_ASSERT_SAME(a_class_code, clock, reset, valid3_ff, cls3_ff == CLASS_ID_0 || cls3_ff == CLASS_ID_1 || cls3_ff == CLASS_ID_2)

endmodule

`default_nettype wire

// File: rtl/core/dbd_class_pick.sv
// best class selection and threshold test for one anchor row
// depends on dbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbd_class_pick (
   input  wire logic [dbd_pkg::SCORE_W-1:0] score_0,
   input  wire logic [dbd_pkg::SCORE_W-1:0] score_1,
   input  wire logic [dbd_pkg::SCORE_W-1:0] score_2,
   input  wire logic [dbd_pkg::SCORE_W-1:0] threshold,
   output logic      [dbd_pkg::SCORE_W-1:0] best,
   output logic      [dbd_pkg::CLASS_W-1:0] best_id,
   output logic                             keep
);
   import dbd_pkg::*;

   logic [SCORE_W-1:0] best_01;
   logic [CLASS_W-1:0] id_01;

   // strict compare so the lower index wins a tie
   always_comb begin
      if (score_1 > score_0) begin
         best_01 = score_1;
         id_01   = CLASS_ID_1;
      end else begin
         best_01 = score_0;
         id_01   = CLASS_ID_0;
      end
      if (score_2 > best_01) begin
         best    = score_2;
         best_id = CLASS_ID_2;
      end else begin
         best    = best_01;
         best_id = id_01;
      end
      keep = (best >= threshold);
   end

endmodule

`default_nettype wire

// File: rtl/core/dbd_corner_lane.sv
// one corner lane: doubled-unit corner, gain multiply, round and clamp
// three register stages steered by dbd_pkg::lane_ctl_type; depends on dbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbd_corner_lane (
   input  wire logic                         clock,
   input  wire dbd_pkg::lane_ctl_type        ctl,
   input  wire logic signed [dbd_pkg::COORD_W-1:0] center,
   input  wire logic        [dbd_pkg::COORD_W-1:0] size,
   input  wire logic                         sub_size,
   input  wire logic signed [dbd_pkg::COORD_W-1:0] pad,
   input  wire logic        [dbd_pkg::GAIN_W-1:0]  inv_gain,
   input  wire logic        [dbd_pkg::COORD_W-1:0] lim,
   output logic             [dbd_pkg::COORD_W-1:0] corner
);
   import dbd_pkg::*;

   logic signed [DIFF_W-1:0] center2;
   logic signed [DIFF_W-1:0] size_ext;
   logic signed [DIFF_W-1:0] pad2;
   logic signed [DIFF_W-1:0] diff_in;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] biased;
   logic signed [QUOT_W-1:0] quot;
   logic        [COORD_W-1:0] corner_in;
   logic        [COORD_W-1:0] corner_ff;

   always_comb begin
      center2  = DIFF_W'(center) <<< 1;
      size_ext = $signed(DIFF_W'(size));
      pad2     = DIFF_W'(pad) <<< 1;
      if (sub_size) begin
         diff_in = center2 - size_ext - pad2;
      end else begin
         diff_in = center2 + size_ext - pad2;
      end
   end

   assign prod_in = PROD_W'(diff_ff * $signed({1'b0, inv_gain}));

   // round half up, then clamp to 0 .. lim
   always_comb begin
      biased = prod_ff + PROD_W'(1 << (ROUND_SHIFT - 1));
      quot   = QUOT_W'(biased >>> ROUND_SHIFT);
      if (quot < 0) begin
         corner_in = '0;
      end else if (quot > $signed(QUOT_W'(lim))) begin
         corner_in = lim;
      end else begin
         corner_in = quot[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_diff) begin
         diff_ff <= diff_in;
      end
      if (ctl.load_prod) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_out) begin
         corner_ff <= corner_in;
      end
   end

   assign corner = corner_ff;

endmodule

`default_nettype wire
